>>> src/fvbu_pkg.sv
// fvbu_pkg: shared types, constants and helper functions of the FM voice bulk unpacker.
// No dependencies; imported by the front, queue, back and top-level modules.
`timescale 1ns / 1ps

package fvbu_pkg;

    localparam int FVBU_QUEUE_DEPTH = 4;

    localparam logic [7:0] PACKED_LEN  = 8'd128;
    localparam logic [7:0] SINGLE_LEN  = 8'd155;
    localparam logic [7:0] LAST_INDEX  = 8'd154;
    localparam logic [7:0] OP_BYTES    = 8'd17;
    localparam logic [7:0] OP_PARAMS   = 8'd21;
    localparam logic [7:0] PEG_START   = 8'd102;
    localparam logic [7:0] ALGO_POS    = 8'd110;
    localparam logic [7:0] FBK_POS     = 8'd111;
    localparam logic [7:0] LFOSYNC_POS = 8'd116;
    localparam logic [7:0] TRANS_POS   = 8'd117;
    localparam logic [7:0] NAME_POS    = 8'd118;
    localparam logic [7:0] PEG_INDEX   = 8'd126;
    localparam logic [7:0] ALGO_INDEX  = 8'd134;
    localparam logic [7:0] LFO_INDEX   = 8'd137;
    localparam logic [7:0] NAME_INDEX  = 8'd145;
    localparam logic [6:0] NORM_LIMIT  = 7'd99;

    localparam logic FMT_PACKED = 1'b0;
    localparam logic FMT_SINGLE = 1'b1;

    // One queued request: up to three results, slot last_slot is the final one.
    typedef struct packed {
        logic [2:0][7:0] val;
        logic [2:0][7:0] idx;
        logic [1:0]      last_slot;
    } fvbu_entry_t;

    // floor(v*99/255) above 99; x/255 == (x*0x8081)>>23 for any 16-bit x
    function automatic logic [7:0] norm99(input logic [6:0] v);
        logic [13:0] x;
        logic [29:0] prod;
        begin
            x    = 14'(v) * 14'd99;
            prod = 30'(x) * 30'd32897;
            if (v <= NORM_LIMIT)
                norm99 = {1'b0, v};
            else
                norm99 = 8'(prod >> 23);
        end
    endfunction

    // operator number of a position below 102
    function automatic logic [2:0] op_of(input logic [7:0] pos);
        logic [2:0] op;
        begin
            op = 3'd0;
            for (int i = 1; i < 6; i++)
            begin
                if (pos >= 8'(i * 17))
                    op = op + 3'd1;
            end
            op_of = op;
        end
    endfunction

endpackage

>>> src/fvbu_intf.sv
// fvbu_intf: valid/ready channel interfaces for voice bytes, unpacked parameters
// and the format register write. No dependencies.
`timescale 1ns / 1ps

interface fvbu_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_of_voice;

    modport source (output valid, output data_byte, output first_of_voice, input ready);
    modport sink   (input valid, input data_byte, input first_of_voice, output ready);
endinterface

interface fvbu_param_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [7:0] out_index;
    logic       last_of_run;
    logic       voice_done;

    modport source (output valid, output out_byte, output out_index,
                    output last_of_run, output voice_done, input ready);
    modport sink   (input valid, input out_byte, input out_index,
                    input last_of_run, input voice_done, output ready);
endinterface

interface fvbu_cfg_if;
    logic valid;
    logic ready;
    logic voice_format;

    modport source (output valid, output voice_format, input ready);
    modport sink   (input valid, input voice_format, output ready);
endinterface

>>> src/fvbu_front.sv
// fvbu_front: accepts voice bytes, tracks byte position and held detune, and
// turns each byte into one queue request. Depends on fvbu_pkg and fvbu_intf.
`timescale 1ns / 1ps

module fvbu_front (
    input  logic                 clk,
    input  logic                 rst_n,
    fvbu_byte_if.sink            voice_bytes,
    fvbu_cfg_if.sink             cfg,
    input  logic                 queue_full,
    output logic                 push,
    output fvbu_pkg::fvbu_entry_t push_entry
);
    import fvbu_pkg::*;

    logic       voice_format_reg;
    logic [7:0] pos_reg;
    logic [7:0] pos_next;
    logic [3:0] detune_reg;
    logic [3:0] detune_next;

    logic [7:0] pos;
    logic [7:0] len;
    logic [7:0] pos_inc;
    logic [6:0] v;
    logic [2:0] op;
    logic [7:0] k;
    logic [7:0] u;
    fvbu_entry_t e;

    assign cfg.ready         = 1'b1;
    assign voice_bytes.ready = !queue_full;
    assign push              = voice_bytes.valid && !queue_full;
    assign push_entry        = e;

    always_comb
    begin
        len     = (voice_format_reg == FMT_SINGLE) ? SINGLE_LEN : PACKED_LEN;
        pos     = voice_bytes.first_of_voice ? 8'd0 : pos_reg;
        if (pos >= len)
            pos = 8'd0;
        pos_inc = pos + 8'd1;
        pos_next = (pos_inc >= len) ? 8'd0 : pos_inc;

        v  = voice_bytes.data_byte[6:0];
        op = op_of(pos);
        k  = pos - 8'(op) * OP_BYTES;
        u  = 8'(op) * OP_PARAMS;

        detune_next = detune_reg;
        e.val       = '0;
        e.idx       = '0;
        e.last_slot = 2'd0;

        if (voice_format_reg == FMT_SINGLE)
        begin
            e.val[0] = voice_bytes.data_byte;
            e.idx[0] = pos;
        end
        else if (pos < PEG_START)
        begin
            case (k)
                8'd11:
                begin
                    e.val[0] = {6'd0, v[1:0]};  e.idx[0] = u + 8'd11;
                    e.val[1] = {6'd0, v[3:2]};  e.idx[1] = u + 8'd12;
                    e.last_slot = 2'd1;
                end
                8'd12:
                begin
                    e.val[0] = {5'd0, v[2:0]};  e.idx[0] = u + 8'd13;
                    detune_next = v[6:3];
                end
                8'd13:
                begin
                    e.val[0] = {6'd0, v[1:0]};  e.idx[0] = u + 8'd14;
                    e.val[1] = {5'd0, v[4:2]};  e.idx[1] = u + 8'd15;
                    e.last_slot = 2'd1;
                end
                8'd14:
                begin
                    e.val[0] = {1'b0, v};       e.idx[0] = u + 8'd16;
                end
                8'd15:
                begin
                    e.val[0] = {7'd0, v[0]};    e.idx[0] = u + 8'd17;
                    e.val[1] = {3'd0, v[5:1]};  e.idx[1] = u + 8'd18;
                    e.last_slot = 2'd1;
                end
                8'd16:
                begin
                    e.val[0] = {1'b0, v};       e.idx[0] = u + 8'd19;
                    e.val[1] = {4'd0, detune_reg}; e.idx[1] = u + 8'd20;
                    e.last_slot = 2'd1;
                end
                default:
                begin
                    // operator bytes 0..10
                    e.val[0] = norm99(v);       e.idx[0] = u + k;
                end
            endcase
        end
        else if (pos < ALGO_POS)
        begin
            e.val[0] = norm99(v);
            e.idx[0] = pos - PEG_START + PEG_INDEX;
        end
        else if (pos == ALGO_POS)
        begin
            e.val[0] = {3'd0, v[4:0]};
            e.idx[0] = ALGO_INDEX;
        end
        else if (pos == FBK_POS)
        begin
            e.val[0] = {5'd0, v[2:0]};  e.idx[0] = ALGO_INDEX + 8'd1;
            e.val[1] = {7'd0, v[3]};    e.idx[1] = ALGO_INDEX + 8'd2;
            e.last_slot = 2'd1;
        end
        else if (pos < LFOSYNC_POS)
        begin
            e.val[0] = {1'b0, v};
            e.idx[0] = pos - (FBK_POS + 8'd1) + LFO_INDEX;
        end
        else if (pos == LFOSYNC_POS)
        begin
            e.val[0] = {7'd0, v[0]};    e.idx[0] = LFO_INDEX + 8'd4;
            e.val[1] = {4'd0, v[4:1]};  e.idx[1] = LFO_INDEX + 8'd5;
            e.val[2] = {6'd0, v[6:5]};  e.idx[2] = LFO_INDEX + 8'd6;
            e.last_slot = 2'd2;
        end
        else if (pos == TRANS_POS)
        begin
            e.val[0] = {1'b0, v};
            e.idx[0] = LFO_INDEX + 8'd7;
        end
        else
        begin
            e.val[0] = {1'b0, v};
            e.idx[0] = pos - NAME_POS + NAME_INDEX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            voice_format_reg <= FMT_PACKED;
            pos_reg          <= 8'd0;
            detune_reg       <= 4'd0;
        end
        else
        begin
            if (cfg.valid)
                voice_format_reg <= cfg.voice_format;
            if (push)
            begin
                pos_reg    <= pos_next;
                detune_reg <= detune_next;
            end
        end
    end

endmodule

>>> src/fvbu_queue.sv
// fvbu_queue: small register FIFO of unpack requests between front and back.
// Depends on fvbu_pkg.
`timescale 1ns / 1ps

module fvbu_queue #(
    parameter int Depth = fvbu_pkg::FVBU_QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  fvbu_pkg::fvbu_entry_t push_entry,
    output logic                  full,
    input  logic                  pop,
    output logic                  head_valid,
    output fvbu_pkg::fvbu_entry_t head_entry
);
    import fvbu_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    fvbu_entry_t     slots_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] count_reg;
    logic            do_push;
    logic            do_pop;

    assign full       = (count_reg == CntW'(Depth));
    assign head_valid = (count_reg != '0);
    assign head_entry = slots_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (!do_push && do_pop)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

>>> src/fvbu_back.sv
// fvbu_back: walks the slots of the head request and drives the registered
// parameter output channel. Depends on fvbu_pkg and fvbu_intf.
`timescale 1ns / 1ps

module fvbu_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  fvbu_pkg::fvbu_entry_t head_entry,
    output logic                  pop,
    fvbu_param_if.source          params
);
    import fvbu_pkg::*;

    logic [1:0] slot_reg;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic [7:0] out_index_reg;
    logic       last_reg;
    logic       done_reg;
    logic       advance;
    logic       load;
    logic       at_last;
    logic [7:0] sel_idx;

    assign advance = !out_valid_reg || params.ready;
    assign load    = advance && head_valid;
    assign at_last = (slot_reg == head_entry.last_slot);
    assign pop     = load && at_last;
    assign sel_idx = head_entry.idx[slot_reg];

    assign params.valid       = out_valid_reg;
    assign params.out_byte    = out_byte_reg;
    assign params.out_index   = out_index_reg;
    assign params.last_of_run = last_reg;
    assign params.voice_done  = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
                out_valid_reg <= head_valid;
            if (load)
                slot_reg <= at_last ? 2'd0 : slot_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg  <= head_entry.val[slot_reg];
            out_index_reg <= sel_idx;
            last_reg      <= at_last;
            done_reg      <= (sel_idx == LAST_INDEX);
        end
    end

endmodule

>>> src/fm_voice_bulk_unpacker.sv
// FM voice bulk unpacker top level: front classifier, request queue, output walker.
// Depends on fvbu_pkg, fvbu_intf, fvbu_front, fvbu_queue and fvbu_back.
//
// Usage:
//   voice_bytes : valid/ready stream of record bytes; first_of_voice restarts
//                 the byte position at zero.
//   params      : valid/ready stream of unpacked parameters with their index,
//                 last_of_run on the final result of a byte and voice_done on
//                 index 154.
//   cfg         : one-bit voice_format write (0 packed 128 bytes, 1 single
//                 155-byte passthrough); always ready, write only when idle.
// The first result of a byte is held in a queue slot and then loaded into the
// output register. Throughput: one byte per cycle is accepted while the request
// queue has room; the output side emits one result per cycle while the
// receiver is ready, so a byte giving 1 to 3 results is sent one result at a
// time. The single output port sets the overall rate.
// Reset clears the position, held detune, format (packed) and the queue.
// When the receiver stalls, the output register holds its result and the
// queue fills; voice_bytes.ready drops once QueueDepth requests are waiting.
`timescale 1ns / 1ps

module fm_voice_bulk_unpacker #(
    parameter int QueueDepth = fvbu_pkg::FVBU_QUEUE_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    fvbu_byte_if.sink    voice_bytes,
    fvbu_cfg_if.sink     cfg,
    fvbu_param_if.source params
);
    import fvbu_pkg::*;

    logic        queue_full;
    logic        push;
    fvbu_entry_t push_entry;
    logic        pop;
    logic        head_valid;
    fvbu_entry_t head_entry;

    fvbu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .voice_bytes(voice_bytes),
        .cfg        (cfg),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    fvbu_queue #(
        .Depth(QueueDepth)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_entry(push_entry),
        .full      (queue_full),
        .pop       (pop),
        .head_valid(head_valid),
        .head_entry(head_entry)
    );

    fvbu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_valid(head_valid),
        .head_entry(head_entry),
        .pop       (pop),
        .params    (params)
    );

endmodule
